// ===== hdl/psa_pkg.sv =====
// ----------------------------------------------------------------------------
// psa_pkg
// Shared sizes, widths, command and status codes, and the slot search result
// type of the page slot allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int MaxPages = 256;
  localparam int MaxSlots = 16;

  localparam int PageW  = 9;
  localparam int SlotW  = 4;
  localparam int CountW = 13;
  localparam int CfgW   = 5;
  localparam int CmdW   = 2;
  localparam int StatW  = 2;

  localparam logic [CountW-1:0] CountMax   = 13'd8191;
  localparam logic [CfgW-1:0]   SlotsReset = 5'd16;

  localparam logic [CmdW-1:0] CmdInsert = 2'd0;
  localparam logic [CmdW-1:0] CmdDelete = 2'd1;
  localparam logic [CmdW-1:0] CmdCheck  = 2'd2;

  localparam logic [StatW-1:0] StatOk       = 2'd0;
  localparam logic [StatW-1:0] StatNotFound = 2'd1;
  localparam logic [StatW-1:0] StatFull     = 2'd2;

  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] idx;
    logic             fill;
    logic             hit;
  } psa_find_t;

endpackage

// ===== hdl/page_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// page_slot_allocator
// Slot allocator over pages with a free-page list kept in two RAMs.
//
// Command channel: drive cmd_i, page_in_i and slot_in_i with start; the word
// is taken at a clock edge where start is high and busy is low. Insert takes
// the lowest free slot of the head free page; delete frees an occupied slot;
// check reports whether a slot is occupied.
// Result channel: done_o marks one cycle carrying status_o, page_out_o,
// slot_out_o and record_count_o. The receiver cannot stall; it must take the
// word in that cycle.
// Result: done_o is registered from StExec, so the strobe follows the execute step.
// Commands: a new command is taken only back in StIdle; each one passes StExec,
// and an insert that moves the head to the next free page also passes StAdv. Each
// command reads the flag word and link of one page, then writes them back;
// moving the head takes the StAdv step to follow the link or append a fresh page.
// Configuration: one write channel for slots_per_page, taken while idle.
// Reset: busy stays high for one cycle while page 1 is cleared; the table
// then holds one empty page and slots_per_page is 16.
// ----------------------------------------------------------------------------
module page_slot_allocator
  import psa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [CmdW-1:0]   cmd_i,
  input  logic [PageW-1:0]  page_in_i,
  input  logic [SlotW-1:0]  slot_in_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CfgW-1:0]   cfg_data_i,
  output logic              done_o,
  output logic [StatW-1:0]  status_o,
  output logic [PageW-1:0]  page_out_o,
  output logic [SlotW-1:0]  slot_out_o,
  output logic [CountW-1:0] record_count_o
);

  localparam int AddrW = $clog2(MaxPages);

  typedef enum logic [1:0] {StInit, StIdle, StExec, StAdv} state_e;

  state_e             state_q, state_d;
  logic [CmdW-1:0]    cmd_q, cmd_d;
  logic [PageW-1:0]   page_q, page_d;
  logic [SlotW-1:0]   slot_q, slot_d;
  logic [AddrW-1:0]   addr_q, addr_d;
  logic [PageW-1:0]   head_q, head_d;
  logic [PageW-1:0]   pages_q, pages_d;
  logic [CountW-1:0]  total_q, total_d;
  logic [CfgW-1:0]    slots_q, slots_d;
  logic               done_q, done_d;
  logic [StatW-1:0]   stat_q, stat_d;
  logic [PageW-1:0]   pout_q, pout_d;
  logic [SlotW-1:0]   sout_q, sout_d;

  logic                occ_we, occ_re;
  logic [AddrW-1:0]    occ_waddr, rd_addr;
  logic [MaxSlots-1:0] occ_wdata, occ_rd;
  logic                link_we;
  logic [AddrW-1:0]    link_waddr;
  logic [PageW-1:0]    link_wdata, link_rd;
  logic [PageW-1:0]    head_m1, page_m1;
  logic                accept;
  psa_find_t           find;

  psa_ram #(.Width(MaxSlots), .Depth(MaxPages)) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wdata_i (occ_wdata),
    .re_i    (occ_re),
    .raddr_i (rd_addr),
    .rdata_o (occ_rd)
  );

  psa_ram #(.Width(PageW), .Depth(MaxPages)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (occ_re),
    .raddr_i (rd_addr),
    .rdata_o (link_rd)
  );

  psa_slot_find u_find (
    .occ_i   (occ_rd),
    .slots_i (slots_q),
    .slot_i  (slot_q),
    .find_o  (find)
  );

  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = !busy;
  assign accept      = start && !busy;
  assign head_m1     = head_q - PageW'(1);
  assign page_m1     = page_in_i - PageW'(1);
  assign occ_re      = accept;
  assign rd_addr     = (cmd_i == CmdInsert) ? head_m1[AddrW-1:0] : page_m1[AddrW-1:0];

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    page_d     = page_q;
    slot_d     = slot_q;
    addr_d     = addr_q;
    head_d     = head_q;
    pages_d    = pages_q;
    total_d    = total_q;
    slots_d    = slots_q;
    done_d     = 1'b0;
    stat_d     = stat_q;
    pout_d     = pout_q;
    sout_d     = sout_q;
    occ_we     = 1'b0;
    occ_waddr  = addr_q;
    occ_wdata  = occ_rd;
    link_we    = 1'b0;
    link_waddr = addr_q;
    link_wdata = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      slots_d = cfg_data_i;
    end

    case (state_q)
      StInit: begin
        occ_we     = 1'b1;
        occ_waddr  = '0;
        occ_wdata  = '0;
        link_we    = 1'b1;
        link_waddr = '0;
        state_d    = StIdle;
      end
      StIdle: begin
        if (accept) begin
          cmd_d   = cmd_i;
          page_d  = page_in_i;
          slot_d  = slot_in_i;
          addr_d  = rd_addr;
          state_d = StExec;
        end
      end
      StExec: begin
        done_d  = 1'b1;
        state_d = StIdle;
        stat_d  = StatNotFound;
        pout_d  = page_q;
        sout_d  = slot_q;
        if (cmd_q == CmdInsert) begin
          stat_d = StatFull;
          pout_d = '0;
          sout_d = '0;
          if (head_q != '0 && head_q <= pages_q) begin
            if (!find.found) begin
              link_we = 1'b1;
              state_d = StAdv;
            end else begin
              occ_we    = 1'b1;
              occ_wdata = occ_rd | (MaxSlots'(1) << find.idx);
              if (total_q < CountMax) begin
                total_d = total_q + CountW'(1);
              end
              stat_d = StatOk;
              pout_d = head_q;
              sout_d = find.idx;
              if (find.fill) begin
                link_we = 1'b1;
                state_d = StAdv;
              end
            end
          end else begin
            head_d = '0;
          end
        end else if (cmd_q == CmdDelete || cmd_q == CmdCheck) begin
          if (page_q != '0 && page_q <= pages_q && find.hit) begin
            stat_d = StatOk;
            if (cmd_q == CmdDelete) begin
              occ_we    = 1'b1;
              occ_wdata = occ_rd & ~(MaxSlots'(1) << slot_q);
              if (total_q != '0) begin
                total_d = total_q - CountW'(1);
              end
              if (!find.found && page_q != head_q) begin
                link_we    = 1'b1;
                link_wdata = head_q;
                head_d     = page_q;
              end
            end
          end
        end
      end
      StAdv: begin
        state_d = StIdle;
        if (link_rd == '0 || link_rd > pages_q) begin
          if (32'(pages_q) < MaxPages) begin
            occ_we     = 1'b1;
            occ_waddr  = pages_q[AddrW-1:0];
            occ_wdata  = '0;
            link_we    = 1'b1;
            link_waddr = pages_q[AddrW-1:0];
            pages_d    = pages_q + PageW'(1);
            head_d     = pages_q + PageW'(1);
          end else begin
            head_d = '0;
          end
        end else begin
          head_d = link_rd;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      cmd_q   <= CmdInsert;
      page_q  <= '0;
      slot_q  <= '0;
      addr_q  <= '0;
      head_q  <= PageW'(1);
      pages_q <= PageW'(1);
      total_q <= '0;
      slots_q <= SlotsReset;
      done_q  <= 1'b0;
      stat_q  <= StatOk;
      pout_q  <= '0;
      sout_q  <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      page_q  <= page_d;
      slot_q  <= slot_d;
      addr_q  <= addr_d;
      head_q  <= head_d;
      pages_q <= pages_d;
      total_q <= total_d;
      slots_q <= slots_d;
      done_q  <= done_d;
      stat_q  <= stat_d;
      pout_q  <= pout_d;
      sout_q  <= sout_d;
    end
  end

  assign done_o         = done_q;
  assign status_o       = stat_q;
  assign page_out_o     = pout_q;
  assign slot_out_o     = sout_q;
  assign record_count_o = total_q;

  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == StExec))
    else $error("result strobe without an executed command");

  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 done_o)
    else $error("accepted command gave no result two cycles later");

  a_head_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= pages_q)
    else $error("free head points past the pages in use");

  a_pages_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q == StInit) |=> pages_q >= $past(pages_q) && pages_q != '0)
    else $error("page count shrank");

endmodule

// ===== hdl/psa_ram.sv =====
// ----------------------------------------------------------------------------
// psa_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module psa_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/psa_slot_find.sv =====
// ----------------------------------------------------------------------------
// psa_slot_find
// Slot search on one page flag word: lowest free slot, whether taking it
// fills the page, and whether a given slot is valid and occupied.
// ----------------------------------------------------------------------------
module psa_slot_find
  import psa_pkg::*;
(
  input  logic [MaxSlots-1:0] occ_i,
  input  logic [CfgW-1:0]     slots_i,
  input  logic [SlotW-1:0]    slot_i,
  output psa_find_t           find_o
);

  logic [CfgW-1:0]     n_eff;
  logic [MaxSlots-1:0] mask;
  logic [MaxSlots-1:0] free_vec;
  logic [MaxSlots-1:0] occ_new;
  logic [MaxSlots-1:0] occ_sh;
  logic [SlotW-1:0]    idx;

  always_comb begin
    if (slots_i == '0) begin
      n_eff = CfgW'(1);
    end else if (32'(slots_i) > MaxSlots) begin
      n_eff = CfgW'(MaxSlots);
    end else begin
      n_eff = slots_i;
    end
    for (int i = 0; i < MaxSlots; i++) begin
      mask[i] = (i < int'(n_eff));
    end
  end

  assign free_vec = ~occ_i & mask;

  always_comb begin
    idx = '0;
    for (int i = MaxSlots - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        idx = SlotW'(i);
      end
    end
  end

  assign occ_new = occ_i | (MaxSlots'(1) << idx);
  assign occ_sh  = occ_i >> slot_i;

  assign find_o.found = |free_vec;
  assign find_o.idx   = idx;
  assign find_o.fill  = ((~occ_new & mask) == '0);
  assign find_o.hit   = (32'(slot_i) < 32'(n_eff)) && occ_sh[0];

endmodule

// ===== verif/page_slot_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// page_slot_allocator_tb
// Self-checking bench for the page slot allocator. A short table of commands,
// some with known replies, opens the run, then phases of random commands at
// different slot counts fill the table up to its last page. Every other reply
// word is checked against a bit-accurate copy of the page flags, the free-page
// links and the head pointer kept in the bench.
// ----------------------------------------------------------------------------
module page_slot_allocator_tb
  import psa_pkg::*;
();

  localparam int PageCnt    = MaxPages;
  localparam int SlotCnt    = MaxSlots;
  localparam int PageIdxW   = $clog2(PageCnt);
  localparam int QuietLimit = 2000;

  localparam logic [CmdW-1:0] CmdSpare = 2'd3;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [PageW-1:0]  page;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] count;
  } reply_t;

  typedef struct packed {
    logic              wr_cfg;
    logic [CfgW-1:0]   cfg_val;
    logic [CmdW-1:0]   cmd;
    logic [PageW-1:0]  page;
    logic [SlotW-1:0]  slot;
    logic              typed;
    logic [StatW-1:0]  w_status;
    logic [PageW-1:0]  w_page;
    logic [SlotW-1:0]  w_slot;
    logic [CountW-1:0] w_count;
  } dir_row_t;

  typedef struct {
    logic [CfgW-1:0] cfg;
    int              items;
    int              ins_pct;
    bit              idle;
  } phase_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              start          = 1'b0;
  logic              busy;
  logic [CmdW-1:0]   cmd_i          = '0;
  logic [PageW-1:0]  page_in_i      = '0;
  logic [SlotW-1:0]  slot_in_i      = '0;
  logic              cfg_valid_i    = 1'b0;
  logic              cfg_ready_o;
  logic [CfgW-1:0]   cfg_data_i     = '0;
  logic              done_o;
  logic [StatW-1:0]  status_o;
  logic [PageW-1:0]  page_out_o;
  logic [SlotW-1:0]  slot_out_o;
  logic [CountW-1:0] record_count_o;

  logic [SlotCnt-1:0] flags_mem [PageCnt];
  logic [PageW-1:0]   link_mem  [PageCnt];
  logic [PageW-1:0]   head_pg;
  logic [PageW-1:0]   pages_used;
  logic [CountW-1:0]  total_recs;
  logic [CfgW-1:0]    slots_cfg;

  reply_t slot_table_replies [$];
  reply_t want_reply;
  int     fail_cnt    = 0;
  int     quiet_cycles = 0;

  dir_row_t dir_rows [26] = '{
    '{0, 0,  CmdCheck,  1,   0,  1, StatNotFound, 1,   0,  0},
    '{0, 0,  CmdInsert, 0,   0,  1, StatOk,       1,   0,  1},
    '{0, 0,  CmdCheck,  1,   0,  1, StatOk,       1,   0,  1},
    '{0, 0,  CmdDelete, 0,   0,  1, StatNotFound, 0,   0,  1},
    '{0, 0,  CmdDelete, 256, 15, 1, StatNotFound, 256, 15, 1},
    '{0, 0,  CmdCheck,  511, 15, 1, StatNotFound, 511, 15, 1},
    '{0, 0,  CmdSpare,  170, 10, 1, StatNotFound, 170, 10, 1},
    '{0, 0,  CmdInsert, 511, 15, 1, StatOk,       1,   1,  2},
    '{0, 0,  CmdDelete, 1,   0,  1, StatOk,       1,   0,  1},
    '{0, 0,  CmdDelete, 1,   0,  1, StatNotFound, 1,   0,  1},
    '{0, 0,  CmdInsert, 0,   0,  1, StatOk,       1,   0,  2},
    '{0, 0,  CmdDelete, 2,   0,  1, StatNotFound, 2,   0,  2},
    '{1, 2,  CmdInsert, 0,   0,  0, StatOk,       0,   0,  0},
    '{0, 0,  CmdCheck,  1,   2,  0, StatOk,       0,   0,  0},
    '{0, 0,  CmdDelete, 1,   1,  0, StatOk,       0,   0,  0},
    '{0, 0,  CmdInsert, 0,   0,  0, StatOk,       0,   0,  0},
    '{0, 0,  CmdInsert, 0,   0,  0, StatOk,       0,   0,  0},
    '{0, 0,  CmdInsert, 0,   0,  0, StatOk,       0,   0,  0},
    '{0, 0,  CmdDelete, 1,   0,  0, StatOk,       0,   0,  0},
    '{0, 0,  CmdInsert, 0,   0,  0, StatOk,       0,   0,  0},
    '{0, 0,  CmdInsert, 0,   0,  0, StatOk,       0,   0,  0},
    '{1, 0,  CmdInsert, 0,   0,  0, StatOk,       0,   0,  0},
    '{0, 0,  CmdInsert, 0,   0,  0, StatOk,       0,   0,  0},
    '{0, 0,  CmdInsert, 0,   0,  0, StatOk,       0,   0,  0},
    '{1, 31, CmdInsert, 0,   0,  0, StatOk,       0,   0,  0},
    '{0, 0,  CmdCheck,  4,   15, 0, StatOk,       0,   0,  0}
  };

  phase_t phase_plan [6] = '{
    '{5'd31, 80,  45, 1'b1},
    '{5'd3,  60,  45, 1'b1},
    '{5'd1,  300, 95, 1'b1},
    '{5'd0,  50,  45, 1'b1},
    '{5'd16, 20,  40, 1'b1},
    '{5'd2,  30,  45, 1'b0}
  };

  page_slot_allocator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .page_in_i     (page_in_i),
    .slot_in_i     (slot_in_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .page_out_o    (page_out_o),
    .slot_out_o    (slot_out_o),
    .record_count_o(record_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int used_slots();
    if (slots_cfg == '0) return 1;
    if (slots_cfg > SlotCnt) return SlotCnt;
    return int'(slots_cfg);
  endfunction

  function automatic logic [SlotCnt-1:0] slot_mask();
    logic [SlotCnt:0] wide;
    wide = ({{SlotCnt{1'b0}}, 1'b1} << used_slots()) - 1'b1;
    return wide[SlotCnt-1:0];
  endfunction

  // advance the head past a page that has no free slot
  function automatic void move_head(logic [PageW-1:0] pg);
    logic [PageW-1:0] nxt;
    nxt = link_mem[PageIdxW'(pg - 1'b1)];
    link_mem[PageIdxW'(pg - 1'b1)] = '0;
    if (nxt == '0 || nxt > pages_used) begin
      if (pages_used < PageCnt) begin
        pages_used = pages_used + 1'b1;
        flags_mem[PageIdxW'(pages_used - 1'b1)] = '0;
        link_mem[PageIdxW'(pages_used - 1'b1)] = '0;
        nxt = pages_used;
      end else begin
        nxt = '0;
      end
    end
    head_pg = nxt;
  endfunction

  function automatic reply_t slot_table_step(logic [CmdW-1:0] cmd, logic [PageW-1:0] pg,
                                             logic [SlotW-1:0] sl);
    reply_t              r;
    logic [SlotCnt-1:0]  msk;
    logic [SlotCnt-1:0]  occ;
    logic [SlotCnt-1:0]  free_bits;
    logic                was_full;
    logic [SlotW-1:0]    s;
    logic [PageIdxW-1:0] hidx;
    logic [PageIdxW-1:0] pidx;
    msk = slot_mask();
    hidx = PageIdxW'(head_pg - 1'b1);
    pidx = PageIdxW'(pg - 1'b1);
    r.status = StatNotFound;
    r.page = pg;
    r.slot = sl;
    if (cmd == CmdInsert) begin
      r.status = StatFull;
      r.page = '0;
      r.slot = '0;
      if (head_pg != '0 && head_pg <= pages_used) begin
        occ = flags_mem[hidx];
        free_bits = ~occ & msk;
        if (free_bits == '0) begin
          move_head(head_pg);
        end else begin
          s = '0;
          while (!free_bits[s]) s = s + 1'b1;
          occ[s] = 1'b1;
          flags_mem[hidx] = occ;
          if (total_recs < CountMax) total_recs = total_recs + 1'b1;
          r.status = StatOk;
          r.page = head_pg;
          r.slot = s;
          if ((~occ & msk) == '0) move_head(head_pg);
        end
      end else begin
        head_pg = '0;
      end
    end else if (cmd == CmdDelete || cmd == CmdCheck) begin
      if (pg >= 1 && pg <= pages_used && int'(sl) < used_slots() && flags_mem[pidx][sl]) begin
        r.status = StatOk;
        if (cmd == CmdDelete) begin
          was_full = ((~flags_mem[pidx] & msk) == '0);
          flags_mem[pidx][sl] = 1'b0;
          if (total_recs > 0) total_recs = total_recs - 1'b1;
          if (was_full && pg != head_pg) begin
            link_mem[pidx] = head_pg;
            head_pg = pg;
          end
        end
      end
    end
    r.count = total_recs;
    return r;
  endfunction

  // find a slot that currently holds a record
  function automatic bit pick_record(output logic [PageW-1:0] pg, output logic [SlotW-1:0] sl);
    logic [SlotCnt-1:0] occ;
    logic [SlotW-1:0]   b;
    for (int tries = 0; tries < 8; tries++) begin
      pg = PageW'($urandom_range(1, int'(pages_used)));
      occ = flags_mem[PageIdxW'(pg - 1'b1)] & slot_mask();
      if (occ != '0) begin
        b = SlotW'($urandom_range(0, SlotCnt - 1));
        while (!occ[b]) b = b + 1'b1;
        sl = b;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic issue_word(logic [CmdW-1:0] cmd, logic [PageW-1:0] pg, logic [SlotW-1:0] sl,
                            bit typed, reply_t typed_reply);
    reply_t got;
    @(negedge clk_i);
    start     <= 1'b1;
    cmd_i     <= cmd;
    page_in_i <= pg;
    slot_in_i <= sl;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    got = slot_table_step(cmd, pg, sl);
    slot_table_replies.push_back(typed ? typed_reply : got);
  endtask

  task automatic hold_off(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  task automatic drain_replies();
    hold_off(1);
    while (slot_table_replies.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_slot_count(logic [CfgW-1:0] val);
    drain_replies();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    slots_cfg = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (slot_table_replies.size() == 0) begin
        $error("unexpected reply word: status %0d page %0d slot %0d", status_o, page_out_o,
               slot_out_o);
        fail_cnt++;
      end else begin
        want_reply = slot_table_replies.pop_front();
        if (want_reply.status !== status_o) begin
          $error("status: expected %0d, got %0d", want_reply.status, status_o);
          fail_cnt++;
        end
        if (want_reply.page !== page_out_o) begin
          $error("page_out: expected %0d, got %0d", want_reply.page, page_out_o);
          fail_cnt++;
        end
        if (want_reply.slot !== slot_out_o) begin
          $error("slot_out: expected %0d, got %0d", want_reply.slot, slot_out_o);
          fail_cnt++;
        end
        if (want_reply.count !== record_count_o) begin
          $error("record_count: expected %0d, got %0d", want_reply.count, record_count_o);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    reply_t           want;
    phase_t           plan;
    int               r;
    logic [CmdW-1:0]  c;
    logic [PageW-1:0] p;
    logic [SlotW-1:0] s;
    for (int i = 0; i < PageCnt; i++) begin
      flags_mem[i] = '0;
      link_mem[i]  = '0;
    end
    head_pg    = PageW'(1);
    pages_used = PageW'(1);
    total_recs = '0;
    slots_cfg  = SlotsReset;
    phase_plan[5].cfg = CfgW'($urandom_range(2, 30));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr_cfg) begin
        write_slot_count(dir_rows[i].cfg_val);
      end else begin
        want = '{dir_rows[i].w_status, dir_rows[i].w_page, dir_rows[i].w_slot,
                 dir_rows[i].w_count};
        issue_word(dir_rows[i].cmd, dir_rows[i].page, dir_rows[i].slot, dir_rows[i].typed, want);
      end
    end

    foreach (phase_plan[ph]) begin
      plan = phase_plan[ph];
      write_slot_count(plan.cfg);
      for (int n = 0; n < plan.items; n++) begin
        if (ph == 0 && n == plan.items / 2) drain_replies();
        if (plan.idle && $urandom_range(0, 99) < 15) hold_off($urandom_range(1, 10));
        r = $urandom_range(0, 99);
        if (r < plan.ins_pct) begin
          c = CmdInsert;
          p = PageW'($urandom);
          s = SlotW'($urandom);
        end else if (r >= 97) begin
          c = CmdW'($urandom);
          p = PageW'($urandom);
          s = SlotW'($urandom);
        end else begin
          c = ($urandom_range(0, 2) == 0) ? CmdCheck : CmdDelete;
          if (!($urandom_range(0, 9) < 7 && pick_record(p, s))) begin
            p = PageW'($urandom_range(1, int'(pages_used)));
            s = SlotW'($urandom);
          end
        end
        issue_word(c, p, s, 1'b0, '0);
      end
    end

    drain_replies();
    repeat (6) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
